// ===== rtl/core/dfs_pkg.sv =====
// shared types and constants for the delimited field selector
package dfs_pkg;

    localparam int TABLE_WORDS = 32;
    localparam int WORD_W      = 32;
    localparam int TABLE_BITS  = TABLE_WORDS * WORD_W;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int FIELD_W     = $clog2(TABLE_BITS + 1) + 0;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] NL_CHAR  = 8'd10;
    localparam logic [7:0] TAB_CHAR = 8'd9;

    typedef enum logic
    {
        CMD_DATA  = 1'b0,
        CMD_WRITE = 1'b1
    } dfs_cmd_t;

    // one output word as produced by the parser
    typedef struct packed
    {
        logic       vld;
        logic [7:0] data;
        logic       last;
    } dfs_res_t;

endpackage

// ===== rtl/core/delimited_field_selector_top.sv =====
// top level of the delimited field selector
// Passes through only the selected delimited fields of a byte stream. One input word is
// taken per cycle while the output queue has room; a newline gives one output word, a
// byte of a printed field gives one, and the first byte of a printed field after an
// earlier one on the same line gives two (the delimiter, then the byte). The output words
// of an item are registered in the output queue when it is taken. This four-word queue
// accepts input whenever it has room for two words, so the input stalls only when output
// words back up in the queue. The 32 x 32 selection table sits in a memory with a
// registered read, prefetched at the word of the next field; its per-word valid bits
// make it read as zero after reset, with no clearing pass.
module delimited_field_selector_top
#(
    parameter int MAX_FIELDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // delimiter
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // data_byte[7:0], word_index[12:8], word_value[44:13]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast
);
    import dfs_pkg::*;

    logic                 accept;
    logic                 room;
    logic                 tbl_we;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    sel_word;
    dfs_res_t [1:0]       res;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;
    assign tbl_we        = accept && (dfs_cmd_t'(s_axis_tuser) == CMD_WRITE);

    dfs_sel_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (s_axis_tdata[12:8]),
        .wr_data (s_axis_tdata[44:13]),
        .rd_addr (rd_addr),
        .rd_word (sel_word)
    );

    dfs_parser #(.MAX_FIELDS(MAX_FIELDS)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .command   (s_axis_tuser),
        .data_byte (s_axis_tdata[7:0]),
        .sel_word  (sel_word),
        .rd_addr   (rd_addr),
        .res       (res)
    );

    dfs_out_fifo u_fifo
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/dfs_sel_table.sv =====
// selection table memory with valid bits and write-to-read forwarding
module dfs_sel_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [dfs_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [dfs_pkg::WORD_W-1:0]  wr_data,
    input  logic [dfs_pkg::ADDR_W-1:0]  rd_addr,
    output logic [dfs_pkg::WORD_W-1:0]  rd_word
);
    import dfs_pkg::*;

    logic [WORD_W-1:0]      mem [TABLE_WORDS];
    logic [TABLE_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]      rd_raw_reg;
    logic                   rd_valid_reg;
    logic                   fwd_reg;
    logic [WORD_W-1:0]      fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg   <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            // a write in the same cycle as the read wins over the old entry
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_word = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_word = rd_raw_reg;
        end
        else
        begin
            rd_word = '0;
        end
    end

endmodule

// ===== rtl/core/dfs_parser.sv =====
// line and field state, selection decision and result generation
module dfs_parser
#(
    parameter int MAX_FIELDS = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata,
    input  logic                        accept,
    input  logic                        command,
    input  logic [7:0]                  data_byte,
    input  logic [dfs_pkg::WORD_W-1:0]  sel_word,
    output logic [dfs_pkg::ADDR_W-1:0]  rd_addr,
    output dfs_pkg::dfs_res_t [1:0]     res
);
    import dfs_pkg::*;

    localparam int LIMIT = (MAX_FIELDS > TABLE_BITS) ? TABLE_BITS : MAX_FIELDS;

    logic [7:0]         delim_reg;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic               at_start_reg, at_start_next;
    logic               printing_reg, printing_next;
    logic               printed_reg, printed_next;

    logic [FIELD_W-1:0] field_m1;
    logic [FIELD_W-1:0] next_m1;
    logic               in_range;
    logic               selected;
    logic               pf;
    logic               sep;

    assign field_m1 = field_reg - FIELD_W'(1);
    assign in_range = (field_reg <= FIELD_W'(LIMIT));
    assign selected = in_range && sel_word[field_m1[BIT_W-1:0]];
    assign next_m1  = field_next - FIELD_W'(1);
    // prefetch the table word of the field that the next byte will see
    assign rd_addr  = next_m1[BIT_W +: ADDR_W];

    always_comb
    begin
        field_next    = field_reg;
        at_start_next = at_start_reg;
        printing_next = printing_reg;
        printed_next  = printed_reg;
        res           = '0;
        pf            = at_start_reg ? selected : printing_reg;
        sep           = at_start_reg && selected && printed_reg;
        if (accept && (dfs_cmd_t'(command) == CMD_DATA))
        begin
            if (data_byte == NL_CHAR)
            begin
                res[0]        = '{vld: 1'b1, data: NL_CHAR, last: 1'b1};
                field_next    = FIELD_W'(1);
                at_start_next = 1'b1;
                printing_next = 1'b0;
                printed_next  = 1'b0;
            end
            else if (data_byte == delim_reg)
            begin
                if (in_range)
                begin
                    field_next = field_reg + FIELD_W'(1);
                end
                at_start_next = 1'b1;
                printing_next = 1'b0;
            end
            else
            begin
                at_start_next = 1'b0;
                printing_next = pf;
                printed_next  = printed_reg | pf;
                if (sep)
                begin
                    res[0] = '{vld: 1'b1, data: delim_reg, last: 1'b0};
                    res[1] = '{vld: 1'b1, data: data_byte, last: 1'b1};
                end
                else if (pf)
                begin
                    res[0] = '{vld: 1'b1, data: data_byte, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg    <= TAB_CHAR;
            field_reg    <= FIELD_W'(1);
            at_start_reg <= 1'b1;
            printing_reg <= 1'b0;
            printed_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delim_reg <= cfg_wdata;
            end
            field_reg    <= field_next;
            at_start_reg <= at_start_next;
            printing_reg <= printing_next;
            printed_reg  <= printed_next;
        end
    end

endmodule

// ===== rtl/core/dfs_out_fifo.sv =====
// small output queue taking up to two words per cycle
module dfs_out_fifo
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfs_pkg::dfs_res_t [1:0]     res,
    output logic                        room,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import dfs_pkg::*;

    logic [8:0]            entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;
    logic [FIFO_CNT_W-1:0] push_n;
    logic                  pop;

    assign wr_ptr_p1     = wr_ptr_reg + FIFO_PTR_W'(1);
    assign push_n        = FIFO_CNT_W'(res[0].vld) + FIFO_CNT_W'(res[1].vld);
    assign pop           = m_axis_tvalid && m_axis_tready;
    // room for the largest burst one item can cause
    assign room          = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = entry_reg[rd_ptr_reg][8:1];
    assign m_axis_tlast  = entry_reg[rd_ptr_reg][0];

    always_ff @(posedge clk)
    begin
        if (res[0].vld)
        begin
            entry_reg[wr_ptr_reg] <= {res[0].data, res[0].last};
        end
        if (res[1].vld)
        begin
            entry_reg[wr_ptr_p1] <= {res[1].data, res[1].last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[FIFO_PTR_W-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + push_n - FIFO_CNT_W'(pop);
        end
    end

endmodule

// ===== rtl/core/dfs_checker.sv =====
// port-level checks for the delimited field selector, bound to the top level
module dfs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast
);
    import dfs_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // newline into an empty output comes out next cycle as a last word
    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (dfs_cmd_t'(s_axis_tuser) == CMD_DATA) && (s_axis_tdata[7:0] == NL_CHAR)
        && !m_axis_tvalid |=> m_axis_tvalid && (m_axis_tdata == NL_CHAR) && m_axis_tlast)
        else $error("newline not passed through");

    // a table write produces no output
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (dfs_cmd_t'(s_axis_tuser) == CMD_WRITE) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("table write produced output");

    // an idle input with an empty output keeps the output empty
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output word without input");

endmodule

bind delimited_field_selector_top dfs_checker u_dfs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the delimited field selector: directed rows, long line, back pressure, random lines, predictor checked
module testbench;
    import dfs_pkg::*;

    localparam int MAX_FIELDS  = 1024;
    localparam int FIELD_LIMIT = (MAX_FIELDS < TABLE_BITS) ? MAX_FIELDS : TABLE_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 23;
    localparam int RAND_ITEMS  = 200;
    localparam int LONG_FIELDS = 1040;
    localparam logic [8:0] NO_WORD = 9'h000;

    // one input word plus an optional typed-in expectation
    typedef struct packed
    {
        dfs_cmd_t    cmd;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic [31:0] val;
        logic        typed;
        logic [1:0]  n_typed;
        logic [8:0]  typed_0;   // {out_byte, last}
        logic [8:0]  typed_1;
    } stim_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // data_byte, word_index, word_value
    logic        s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // out_byte
    logic        m_axis_tlast;

    // predicted block state
    logic [31:0] sel_table [TABLE_WORDS];
    logic [10:0] fld_num;
    logic        fld_start;
    logic        fld_printing;
    logic        line_printed;
    logic [7:0]  cur_delim;

    logic [8:0]  expected_words [$];   // {out_byte, last}
    stim_t       cur_item;
    stim_t       dir_tab [DIR_ROWS];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    logic        steady;
    logic        hold_req;

    delimited_field_selector_top #(.MAX_FIELDS(MAX_FIELDS)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic stim_t data_row(input logic [7:0] ch, input logic typed,
                                       input logic [1:0] n, input logic [8:0] w0,
                                       input logic [8:0] w1);
        stim_t r;
        r.cmd     = CMD_DATA;
        r.ch      = ch;
        r.idx     = 5'($urandom_range(31));
        r.val     = $urandom();
        r.typed   = typed;
        r.n_typed = n;
        r.typed_0 = w0;
        r.typed_1 = w1;
        return r;
    endfunction

    function automatic stim_t write_row(input logic [4:0] idx, input logic [31:0] val);
        stim_t r;
        r.cmd     = CMD_WRITE;
        r.ch      = 8'($urandom_range(255));
        r.idx     = idx;
        r.val     = val;
        r.typed   = 1'b1;
        r.n_typed = 2'd0;
        r.typed_0 = NO_WORD;
        r.typed_1 = NO_WORD;
        return r;
    endfunction

    // random field content, never the delimiter or a newline
    function automatic logic [7:0] text_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(255));
        while (ch == cur_delim || ch == NL_CHAR);
        return ch;
    endfunction

    task automatic cut_step(input stim_t it, output int n, output logic [8:0] w0,
                            output logic [8:0] w1);
        logic [10:0] bitn;
        logic        sep;
        n   = 0;
        w0  = NO_WORD;
        w1  = NO_WORD;
        sep = 1'b0;
        if (it.cmd == CMD_WRITE)
        begin
            sel_table[it.idx] = it.val;
        end
        else if (it.ch == NL_CHAR)
        begin
            // newline wins even when it is also the delimiter
            n            = 1;
            w0           = {NL_CHAR, 1'b1};
            fld_num      = 11'd1;
            fld_start    = 1'b1;
            fld_printing = 1'b0;
            line_printed = 1'b0;
        end
        else if (it.ch == cur_delim)
        begin
            // counter stops one past the last selectable field
            if (fld_num <= FIELD_LIMIT)
                fld_num = fld_num + 11'd1;
            fld_start    = 1'b1;
            fld_printing = 1'b0;
        end
        else
        begin
            if (fld_start)
            begin
                bitn         = fld_num - 11'd1;
                fld_printing = (fld_num != 0) && (fld_num <= FIELD_LIMIT)
                               && sel_table[bitn[9:5]][bitn[4:0]];
                sep          = fld_printing && line_printed;
                fld_start    = 1'b0;
            end
            if (sep)
            begin
                n  = 1;
                w0 = {cur_delim, 1'b0};
            end
            if (fld_printing)
            begin
                if (n == 0)
                    w0 = {it.ch, 1'b1};
                else
                    w1 = {it.ch, 1'b1};
                n            = n + 1;
                line_printed = 1'b1;
            end
        end
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %02h expected %02h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : monitor
        logic [8:0] got;
        logic [8:0] want;
        logic [8:0] w0;
        logic [8:0] w1;
        int         n;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tlast};
                if (expected_words.size() == 0)
                begin
                    report("unexpected output word", got[8:1], 8'h00);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got[8:1] != want[8:1])
                        report("out_byte", got[8:1], want[8:1]);
                    if (got[0] != want[0])
                        report("last", {7'd0, got[0]}, {7'd0, want[0]});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cut_step(cur_item, n, w0, w1);
                if (cur_item.typed)
                begin
                    n  = int'(cur_item.n_typed);
                    w0 = cur_item.typed_0;
                    w1 = cur_item.typed_1;
                end
                if (n > 0)
                    expected_words.push_back(w0);
                if (n > 1)
                    expected_words.push_back(w1);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // output side: random stalls, or one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 16);
        end
    end

    task automatic offer_word(input stim_t it);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        cur_item = it;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {3'd0, it.val, it.idx, it.ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // table writes may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic load_delimiter(input logic [7:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_delim = value;
    endtask

    task automatic send_text_line();
        int nf;
        int nb;
        nf = $urandom_range(12, 1);
        for (int f = 0; f < nf; f++)
        begin
            if (f != 0)
                offer_word(data_row(cur_delim, 1'b0, 2'd0, NO_WORD, NO_WORD));
            nb = $urandom_range(3);
            for (int b = 0; b < nb; b++)
                offer_word(data_row(text_char(), 1'b0, 2'd0, NO_WORD, NO_WORD));
            if ($urandom_range(15) == 0)
                offer_word(data_row(8'($urandom_range(255)), 1'b0, 2'd0, NO_WORD, NO_WORD));
            if ($urandom_range(24) == 0)
                offer_word(write_row(($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'd0,
                                     $urandom()));
        end
        if ($urandom_range(9) != 0)
            offer_word(data_row(NL_CHAR, 1'b0, 2'd0, NO_WORD, NO_WORD));
    endtask

    initial
    begin : stimulus
        int phase_end;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 48'd0;
        s_axis_tuser  = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        fld_num       = 11'd1;
        fld_start     = 1'b1;
        fld_printing  = 1'b0;
        line_printed  = 1'b0;
        cur_delim     = TAB_CHAR;
        for (int i = 0; i < TABLE_WORDS; i++)
            sel_table[i] = 32'd0;

        // word 0 = 5 selects fields 1 and 3
        dir_tab = '{
            data_row("a",      1'b1, 2'd0, NO_WORD, NO_WORD),           // table clear
            data_row(NL_CHAR,  1'b1, 2'd1, {NL_CHAR, 1'b1}, NO_WORD),
            write_row(5'd0,  32'h0000_0005),
            write_row(5'd31, 32'h8000_0001),
            write_row(5'd7,  32'hFFFF_FFFF),
            write_row(5'd7,  32'h0000_0000),
            data_row("x",      1'b1, 2'd1, {8'h78, 1'b1}, NO_WORD),
            data_row(8'hFF,    1'b1, 2'd1, {8'hFF, 1'b1}, NO_WORD),
            data_row(TAB_CHAR, 1'b1, 2'd0, NO_WORD, NO_WORD),
            data_row("q",      1'b1, 2'd0, NO_WORD, NO_WORD),
            data_row(TAB_CHAR, 1'b1, 2'd0, NO_WORD, NO_WORD),
            data_row(8'h00,    1'b1, 2'd2, {TAB_CHAR, 1'b0}, {8'h00, 1'b1}),
            data_row(NL_CHAR,  1'b1, 2'd1, {NL_CHAR, 1'b1}, NO_WORD),
            // empty selected first field: no output, no separator later
            data_row(TAB_CHAR, 1'b1, 2'd0, NO_WORD, NO_WORD),
            data_row(TAB_CHAR, 1'b1, 2'd0, NO_WORD, NO_WORD),
            data_row("c",      1'b1, 2'd1, {8'h63, 1'b1}, NO_WORD),
            data_row(NL_CHAR,  1'b1, 2'd1, {NL_CHAR, 1'b1}, NO_WORD),
            data_row(8'h80,    1'b0, 2'd0, NO_WORD, NO_WORD),
            data_row(TAB_CHAR, 1'b0, 2'd0, NO_WORD, NO_WORD),
            data_row(8'h7F,    1'b0, 2'd0, NO_WORD, NO_WORD),
            data_row(TAB_CHAR, 1'b0, 2'd0, NO_WORD, NO_WORD),
            data_row("z",      1'b0, 2'd0, NO_WORD, NO_WORD),
            data_row(NL_CHAR,  1'b1, 2'd1, {NL_CHAR, 1'b1}, NO_WORD)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_word(dir_tab[i]);

        // one very long line: last selectable fields, then a saturated field counter
        offer_word(write_row(5'd31, 32'hFFFF_FFFF));
        offer_word(write_row(5'd0, 32'h0000_0001));
        offer_word(data_row(text_char(), 1'b0, 2'd0, NO_WORD, NO_WORD));
        for (int f = 2; f <= LONG_FIELDS; f++)
        begin
            offer_word(data_row(cur_delim, 1'b0, 2'd0, NO_WORD, NO_WORD));
            if (f >= 1020 && (f <= 1030 || f >= 1036))
                offer_word(data_row(text_char(), 1'b0, 2'd0, NO_WORD, NO_WORD));
        end
        offer_word(data_row(NL_CHAR, 1'b0, 2'd0, NO_WORD, NO_WORD));

        // back pressure: output held off while every field prints
        drain_results();
        offer_word(write_row(5'd0, 32'hFFFF_FFFF));
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            offer_word(data_row((i % 3 == 2) ? cur_delim : text_char(),
                                1'b0, 2'd0, NO_WORD, NO_WORD));
        offer_word(data_row(NL_CHAR, 1'b0, 2'd0, NO_WORD, NO_WORD));
        drain_results();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: load_delimiter(8'h00);
                1: load_delimiter(8'hFF);
                2: load_delimiter(8'h2C);      // comma
                3: load_delimiter(NL_CHAR);
                default: load_delimiter(8'($urandom_range(255)));
            endcase
            steady = (p == 2);
            offer_word(write_row(5'd0, $urandom()));
            phase_end = items_sent + RAND_ITEMS / 5;
            while (items_sent < phase_end)
                send_text_line();
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
